// ===== src/sefb_pkg.sv =====
package sefb_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 248;
  localparam int unsigned MAX_BURST       = 9;
  localparam int unsigned BURST_CNT_W     = $clog2(MAX_BURST + 1);
  localparam int unsigned BURST_IDX_W     = $clog2(MAX_BURST);

  localparam logic [7:0] FR_STX     = 8'h02;
  localparam logic [7:0] FR_ETX     = 8'h03;
  localparam logic [7:0] FR_CR      = 8'h0D;
  localparam logic [7:0] FR_LF      = 8'h0A;
  localparam logic [7:0] FR_HDR_LEN = 8'd5;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  // Bytes that one input beat produces, sent in order from index 0.
  typedef struct packed {
    logic [BURST_CNT_W-1:0]      count;
    logic                        trailer;
    logic [MAX_BURST-1:0][7:0]   bytes;
  } burst_t;

endpackage

// ===== src/sefb_plan.sv =====
module sefb_plan #(
  parameter int unsigned MAX_PAYLOAD = sefb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             cmd,
  input  logic [7:0]       dev_num,
  input  logic [7:0]       seq_num,
  input  logic [7:0]       type_code,
  input  logic [7:0]       payload_len,
  input  logic [7:0]       data_byte,
  output sefb_pkg::burst_t burst
);
  import sefb_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic       frame_open, frame_open_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;

  logic [7:0] len_clip;
  logic [7:0] len_byte;
  logic [7:0] hdr_sum;
  logic [7:0] data_sum;

  always_comb begin
    len_clip = (payload_len > MaxLen) ? MaxLen : payload_len;
    len_byte = FR_HDR_LEN + len_clip;
    hdr_sum  = dev_num + seq_num + type_code + len_byte;
    data_sum = running_sum + data_byte;
  end

  always_comb begin
    burst            = '0;
    frame_open_next  = frame_open;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    if (cmd == CMD_HEADER) begin
      burst.bytes[0] = FR_STX;
      burst.bytes[1] = dev_num;
      burst.bytes[2] = seq_num;
      burst.bytes[3] = type_code;
      burst.bytes[4] = len_byte;
      if (len_clip == 8'd0) begin
        // empty payload: close the frame right away
        burst.bytes[5]   = FR_CR;
        burst.bytes[6]   = FR_LF;
        burst.bytes[7]   = hdr_sum + FR_CR + FR_LF;
        burst.bytes[8]   = FR_ETX;
        burst.count      = BURST_CNT_W'(9);
        burst.trailer    = 1'b1;
        frame_open_next  = 1'b0;
        bytes_left_next  = '0;
        running_sum_next = '0;
      end else begin
        burst.count      = BURST_CNT_W'(5);
        frame_open_next  = 1'b1;
        bytes_left_next  = len_clip;
        running_sum_next = hdr_sum;
      end
    end else if (frame_open && bytes_left != 8'd0) begin
      burst.bytes[0] = data_byte;
      if (bytes_left == 8'd1) begin
        burst.bytes[1]   = FR_CR;
        burst.bytes[2]   = FR_LF;
        burst.bytes[3]   = data_sum + FR_CR + FR_LF;
        burst.bytes[4]   = FR_ETX;
        burst.count      = BURST_CNT_W'(5);
        burst.trailer    = 1'b1;
        frame_open_next  = 1'b0;
        bytes_left_next  = '0;
        running_sum_next = '0;
      end else begin
        burst.count      = BURST_CNT_W'(1);
        bytes_left_next  = bytes_left - 8'd1;
        running_sum_next = data_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      frame_open  <= frame_open_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  a_left_open: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 8'd0 |-> frame_open)
    else $error("payload bytes pending with no frame open");

  a_left_max: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= MaxLen)
    else $error("payload count above the clip limit");

endmodule

// ===== src/sefb_ser.sv =====
module sefb_ser (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sefb_pkg::burst_t burst,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             frame_end
);
  import sefb_pkg::*;

  burst_t                 held;
  logic [BURST_CNT_W-1:0] rem;
  logic [BURST_IDX_W-1:0] idx;
  logic                   adv;
  logic                   busy;
  logic                   last_byte;

  always_comb begin
    adv       = !out_valid || out_ready;
    busy      = rem != '0;
    last_byte = rem == BURST_CNT_W'(1);
    // take a new beat once the final byte of the current burst moves out
    ready     = !busy || (last_byte && adv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (busy && adv) begin
        out_byte  <= held.bytes[idx];
        frame_end <= held.trailer && last_byte;
      end
      if (load) begin
        held <= burst;
        rem  <= burst.count;
        idx  <= '0;
      end else if (busy && adv) begin
        rem  <= rem - BURST_CNT_W'(1);
        idx  <= idx + BURST_IDX_W'(1);
      end
    end
  end

  a_rem_max: assert property (@(posedge clk) disable iff (rst)
    rem <= BURST_CNT_W'(MAX_BURST))
    else $error("burst count out of range");

  a_end_etx: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> out_byte == FR_ETX)
    else $error("frame end on a byte other than ETX");

  a_rose_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(rem) != '0)
    else $error("output beat with no burst pending");

  a_idx_rng: assert property (@(posedge clk) disable iff (rst)
    rem != '0 |-> 32'(idx) + 32'(rem) <= MAX_BURST)
    else $error("burst index runs past its bytes");

endmodule

// ===== src/stx_etx_frame_builder_top.sv =====
// Channel  Dir  Beat contents
// s_*      in   tuser: cmd; tdata: dev_num, seq_num, type_code, payload_len, data_byte
// m_*      out  tdata: out_byte; tlast: frame_end
//
// A header beat yields 5 output beats (9 with an empty payload), a payload beat
// 1 (5 on the last payload byte), a stray payload beat none.
// Output beats leave one per cycle from the burst register while m_tready holds;
// an input beat is loaded there first. Payload beats likewise stream one per cycle.
// s_tready drops while a burst has more than one byte left or m_tready stalls it.
// rst is synchronous and clears the frame state and the output stage.
module stx_etx_frame_builder_top #(
  parameter int unsigned MAX_PAYLOAD = sefb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // dev_num, seq_num, type_code, payload_len, data_byte
  input  logic [0:0]  s_tuser,  // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte
  output logic        m_tlast   // frame_end
);
  import sefb_pkg::*;

  logic   accept;
  burst_t burst;

  assign accept = s_tvalid && s_tready;

  sefb_plan #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_plan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (s_tuser[0]),
    .dev_num     (s_tdata[7:0]),
    .seq_num     (s_tdata[15:8]),
    .type_code   (s_tdata[23:16]),
    .payload_len (s_tdata[31:24]),
    .data_byte   (s_tdata[39:32]),
    .burst       (burst)
  );

  sefb_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .frame_end (m_tlast)
  );

endmodule
